/* src/ttws_pkg.sv */
// ttws_pkg: shared types, constants and helpers of the text terminal with scrollback.
// Used by every module of the block; depends on nothing.
package ttws_pkg;

   // Default sizes
   localparam int LINE_WIDTH_DEF    = 80;
   localparam int HISTORY_LINES_DEF = 1024;
   localparam int MAX_ROWS_DEF      = 50;

   // Character codes
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   // Scrolled-view marker
   localparam int         MARK_LEN  = 10;
   localparam logic [7:0] MARK_ATTR = 8'hB0;

   // Register reset values
   localparam logic [7:0]  RESET_COLOR = 8'd7;
   localparam logic [5:0]  RESET_ROWS  = 6'd25;
   localparam logic [15:0] RESET_BLANK = {RESET_COLOR, CHAR_SPACE};

   // Register indexes
   localparam logic CSR_TEXT_COLOR  = 1'b0;
   localparam logic CSR_SCREEN_ROWS = 1'b1;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_PUT  = 2'd0,
      OP_UP   = 2'd1,
      OP_DOWN = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
      logic [5:0] read_row;
      logic [6:0] read_column;
   } req_type;

   typedef struct packed {
      logic [5:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic [11:0] cursor_address;
      logic        view_scrolled;
      logic [9:0]  view_offset;
      logic [15:0] cell_value;
   } rsp_type;

   // Classified request as it sits in the queue
   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
      logic [5:0] read_row;
      logic [6:0] read_column;
   } qent_type;

   // Characters of "[SCROLLED]"
   function automatic logic [7:0] mark_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h5B;
         4'd1:    c = 8'h53;
         4'd2:    c = 8'h43;
         4'd3:    c = 8'h52;
         4'd4:    c = 8'h4F;
         4'd5:    c = 8'h4C;
         4'd6:    c = 8'h4C;
         4'd7:    c = 8'h45;
         4'd8:    c = 8'h44;
         4'd9:    c = 8'h5D;
         default: c = CHAR_SPACE;
      endcase
      return c;
   endfunction

endpackage

/* src/ttws_front.sv */
// ttws_front: request intake; classifies each request and holds it in a two-entry queue.
// Depends on ttws_pkg.
module ttws_front
   import ttws_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     q_valid,
   output qent_type q_data,
   input  logic     q_pop
);

   qent_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   qent_type   ent;

   // Decode mode into an opcode
   always_comb begin
      case (req_data.mode)
         OP_PUT:  ent.op = OP_PUT;
         OP_UP:   ent.op = OP_UP;
         OP_DOWN: ent.op = OP_DOWN;
         default: ent.op = OP_READ;
      endcase
      ent.char_code   = req_data.char_code;
      ent.read_row    = req_data.read_row;
      ent.read_column = req_data.read_column;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (q_pop && q_valid) ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= ent;
   end

endmodule

/* src/ttws_back.sv */
// ttws_back: execution engine; screen and history memories, cursor, view, scroll sequencer
// and the result register. Depends on ttws_pkg.
module ttws_back
   import ttws_pkg::*;
#(
   parameter int LINE_WIDTH    = LINE_WIDTH_DEF,
   parameter int HISTORY_LINES = HISTORY_LINES_DEF,
   parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  qent_type q_data,
   output logic     q_pop,
   input  logic [7:0] text_color,
   input  logic [5:0] screen_rows,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int CLW = $clog2(LINE_WIDTH);
   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int SAW = $clog2(MAX_ROWS * LINE_WIDTH);
   localparam int HW  = $clog2(HISTORY_LINES);
   localparam int CW  = HW + 1;
   localparam int AGW = CW + 1;
   localparam int RAW = $clog2(HISTORY_LINES * LINE_WIDTH);

   typedef enum logic [11:0] {
      S_CLEAR = 12'b0000_0000_0001,
      S_IDLE  = 12'b0000_0000_0010,
      S_SINIT = 12'b0000_0000_0100,
      S_PUSH  = 12'b0000_0000_1000,
      S_SHIFT = 12'b0000_0001_0000,
      S_BLANK = 12'b0000_0010_0000,
      S_FIN   = 12'b0000_0100_0000,
      S_CHAR  = 12'b0000_1000_0000,
      S_RD1   = 12'b0001_0000_0000,
      S_RD2   = 12'b0010_0000_0000,
      S_RDW   = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      PK_RING  = 2'd0,
      PK_SHIFT = 2'd1,
      PK_BLANK = 2'd2
   } pkind_type;

   // Memories
   logic [15:0] live_mem [MAX_ROWS * LINE_WIDTH];
   logic [15:0] ring_mem [HISTORY_LINES * LINE_WIDTH];
   logic [15:0] live_rd_ff, ring_rd_ff;

   // Control and state registers
   state_type      state_ff, state_in;
   logic [SAW-1:0] cnt_ff, cnt_in;
   qent_type       item_ff, item_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CLW-1:0] col_ff, col_in;
   logic [HW-1:0]  head_ff, head_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic [CW-1:0]  shift_ff, shift_in;
   logic           shown_ff, shown_in;
   logic           pend_ff, pend_in;
   logic           src_ring_ff, src_ring_in;
   logic [HW-1:0]  slot_ff, slot_in;
   logic [15:0]    cell_ff, cell_in;
   logic [SAW-1:0] shift_end_ff, shift_end_in;
   logic [SAW-1:0] blank_last_ff, blank_last_in;
   logic [RAW-1:0] ring_base_ff, ring_base_in;
   logic           p_valid_ff, p_valid_in;
   pkind_type      p_kind_ff, p_kind_in;
   logic [SAW-1:0] p_addr_ff, p_addr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   // Memory port controls
   logic           live_we;
   logic [SAW-1:0] live_waddr, live_raddr;
   logic [15:0]    live_wdata;
   logic           ring_we;
   logic [RAW-1:0] ring_waddr, ring_raddr;

   // Helpers
   logic [RW-1:0]  rows;
   logic [15:0]    blank;
   logic [7:0]     x8;
   logic [AGW-1:0] age, slot_sum;
   logic [15:0]    cur_addr;

   assign blank    = {text_color, CHAR_SPACE};
   assign x8       = 8'(item_ff.read_column);
   assign cur_addr = 16'(row_ff) * 16'(LINE_WIDTH) + 16'(col_ff);

   // Clamp the row count into 2..MAX_ROWS
   always_comb begin
      if (screen_rows < 6'd2) rows = RW'(2);
      else if (8'(screen_rows) > 8'(MAX_ROWS)) rows = RW'(MAX_ROWS);
      else rows = RW'(screen_rows);
   end

   // History age and ring slot for a scrolled read
   always_comb begin
      age = AGW'(shift_ff) + AGW'(rows) - AGW'(2) - AGW'(item_ff.read_row);
      slot_sum = AGW'(head_ff) + AGW'(HISTORY_LINES - 1) - age;
      if (slot_sum >= AGW'(HISTORY_LINES)) slot_sum = slot_sum - AGW'(HISTORY_LINES);
   end

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      item_in       = item_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      shift_in      = shift_ff;
      shown_in      = shown_ff;
      pend_in       = pend_ff;
      src_ring_in   = src_ring_ff;
      slot_in       = slot_ff;
      cell_in       = cell_ff;
      shift_end_in  = shift_end_ff;
      blank_last_in = blank_last_ff;
      ring_base_in  = ring_base_ff;
      p_valid_in    = 1'b0;
      p_kind_in     = p_kind_ff;
      p_addr_in     = p_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      live_we       = 1'b0;
      live_waddr    = p_addr_ff;
      live_wdata    = live_rd_ff;
      live_raddr    = cnt_ff;
      ring_we       = 1'b0;
      ring_waddr    = ring_base_ff + RAW'(p_addr_ff);
      ring_raddr    = RAW'(slot_ff) * RAW'(LINE_WIDTH) + RAW'(item_ff.read_column);

      // Drain of the scroll write stage
      if (p_valid_ff) begin
         case (p_kind_ff)
            PK_RING:  ring_we = 1'b1;
            PK_SHIFT: live_we = 1'b1;
            PK_BLANK: begin
               live_we    = 1'b1;
               live_wdata = blank;
            end
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            live_we    = 1'b1;
            live_waddr = cnt_ff;
            live_wdata = RESET_BLANK;
            if (cnt_ff == SAW'(MAX_ROWS * LINE_WIDTH - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + SAW'(1);
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               item_in = q_data;
               cell_in = '0;
               case (q_data.op)
                  OP_PUT: begin
                     shift_in = '0;
                     shown_in = 1'b0;
                     if (row_ff >= rows) begin
                        pend_in  = 1'b1;
                        state_in = S_SINIT;
                     end else begin
                        state_in = S_CHAR;
                     end
                  end
                  OP_UP: begin
                     if (shift_ff < fill_ff &&
                         AGW'(shift_ff) + AGW'(rows) < AGW'(HISTORY_LINES)) begin
                        shift_in = shift_ff + CW'(1);
                        shown_in = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  OP_DOWN: begin
                     if (shift_ff != '0) begin
                        shift_in = shift_ff - CW'(1);
                        shown_in = (shift_ff != CW'(1));
                     end
                     state_in = S_DONE;
                  end
                  default: state_in = S_RD1;
               endcase
            end
         end
         S_CHAR: begin
            if (item_ff.char_code == CHAR_NEWLINE) begin
               row_in   = row_ff + RW'(1);
               col_in   = '0;
               state_in = S_DONE;
            end else if (item_ff.char_code == CHAR_BACKSPACE) begin
               if (col_ff != '0) begin
                  col_in     = col_ff - CLW'(1);
                  live_we    = 1'b1;
                  live_waddr = SAW'(cur_addr - 16'd1);
                  live_wdata = blank;
               end
               state_in = S_DONE;
            end else begin
               live_we    = 1'b1;
               live_waddr = SAW'(cur_addr);
               live_wdata = {text_color, item_ff.char_code};
               if (col_ff == CLW'(LINE_WIDTH - 1)) begin
                  col_in = '0;
                  row_in = row_ff + RW'(1);
                  if (row_ff + RW'(1) >= rows) begin
                     pend_in  = 1'b0;
                     state_in = S_SINIT;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  col_in   = col_ff + CLW'(1);
                  state_in = S_DONE;
               end
            end
         end
         S_SINIT: begin
            shift_end_in  = SAW'(rows - RW'(1)) * SAW'(LINE_WIDTH);
            blank_last_in = SAW'(rows) * SAW'(LINE_WIDTH) - SAW'(1);
            ring_base_in  = RAW'(head_ff) * RAW'(LINE_WIDTH);
            cnt_in        = '0;
            state_in      = S_PUSH;
         end
         S_PUSH: begin
            // Top row into the ring
            live_raddr = cnt_ff;
            p_valid_in = 1'b1;
            p_kind_in  = PK_RING;
            p_addr_in  = cnt_ff;
            if (cnt_ff == SAW'(LINE_WIDTH - 1)) begin
               cnt_in   = '0;
               state_in = S_SHIFT;
            end else begin
               cnt_in = cnt_ff + SAW'(1);
            end
         end
         S_SHIFT: begin
            // Each cell takes the one a row below
            live_raddr = cnt_ff + SAW'(LINE_WIDTH);
            p_valid_in = 1'b1;
            p_kind_in  = PK_SHIFT;
            p_addr_in  = cnt_ff;
            if (cnt_ff + SAW'(1) == shift_end_ff) state_in = S_BLANK;
            cnt_in = cnt_ff + SAW'(1);
         end
         S_BLANK: begin
            p_valid_in = 1'b1;
            p_kind_in  = PK_BLANK;
            p_addr_in  = cnt_ff;
            if (cnt_ff == blank_last_ff) state_in = S_FIN;
            cnt_in = cnt_ff + SAW'(1);
         end
         S_FIN: begin
            row_in   = rows - RW'(1);
            head_in  = (head_ff == HW'(HISTORY_LINES - 1)) ? '0 : head_ff + HW'(1);
            if (fill_ff < CW'(HISTORY_LINES)) fill_in = fill_ff + CW'(1);
            shift_in = '0;
            shown_in = 1'b0;
            state_in = pend_ff ? S_CHAR : S_DONE;
         end
         S_RD1: begin
            live_raddr  = SAW'(item_ff.read_row) * SAW'(LINE_WIDTH) + SAW'(item_ff.read_column);
            src_ring_in = 1'b0;
            slot_in     = HW'(slot_sum);
            if (7'(item_ff.read_row) >= 7'(rows) || x8 >= 8'(LINE_WIDTH)) begin
               cell_in  = '0;
               state_in = S_DONE;
            end else if (!shown_ff || shift_ff == '0) begin
               state_in = S_RDW;
            end else if (item_ff.read_row == '0 &&
                         x8 + 8'(MARK_LEN) >= 8'(LINE_WIDTH)) begin
               cell_in  = {MARK_ATTR, mark_char(4'(x8 + 8'(MARK_LEN) - 8'(LINE_WIDTH)))};
               state_in = S_DONE;
            end else if (age >= AGW'(fill_ff)) begin
               cell_in  = blank;
               state_in = S_DONE;
            end else begin
               state_in = S_RD2;
            end
         end
         S_RD2: begin
            src_ring_in = 1'b1;
            state_in    = S_RDW;
         end
         S_RDW: begin
            cell_in  = src_ring_ff ? ring_rd_ff : live_rd_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.cursor_row     = 6'(row_ff);
               rsp_in.cursor_column  = 7'(col_ff);
               rsp_in.cursor_address = cur_addr[11:0];
               rsp_in.view_scrolled  = shown_ff;
               rsp_in.view_offset    = 10'(shift_ff);
               rsp_in.cell_value     = cell_ff;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         shift_ff     <= '0;
         shown_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         shift_ff     <= shift_in;
         shown_ff     <= shown_in;
         pend_ff      <= pend_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      src_ring_ff   <= src_ring_in;
      slot_ff       <= slot_in;
      cell_ff       <= cell_in;
      shift_end_ff  <= shift_end_in;
      blank_last_ff <= blank_last_in;
      ring_base_ff  <= ring_base_in;
      p_kind_ff     <= p_kind_in;
      p_addr_ff     <= p_addr_in;
      rsp_ff        <= rsp_in;
   end

   // Screen and history memories
   always_ff @(posedge clock) begin
      if (live_we) live_mem[live_waddr] <= live_wdata;
      live_rd_ff <= live_mem[live_raddr];
      if (ring_we) ring_mem[ring_waddr] <= live_rd_ff;
      ring_rd_ff <= ring_mem[ring_raddr];
   end

endmodule

/* src/text_terminal_with_scrollback.sv */
// text_terminal_with_scrollback: top level; register port, request queue and engine.
// Depends on ttws_pkg, ttws_front, ttws_back.
//
//   channel | direction | ports                        | accepted when
//   req     | in        | req_valid/req_ready/req_data | valid && ready at clock edge
//   rsp     | out       | rsp_valid/rsp_ready/rsp_data | valid && ready at clock edge
//   csr     | in        | csr_write_enable/index/data  | write enable high
//
// A scroll pushes the top row into the history ring, then runs the row copy and the clear
// through the single write port of the screen memory.
// After reset a clearing pass fills all MAX_ROWS * LINE_WIDTH screen cells with blanks;
// requests queue but are not started meanwhile.
// Two requests queue ahead of the engine; one result waits in the output register.
module text_terminal_with_scrollback
   import ttws_pkg::*;
#(
   parameter int LINE_WIDTH    = LINE_WIDTH_DEF,
   parameter int HISTORY_LINES = HISTORY_LINES_DEF,
   parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   logic [7:0] text_color_ff;
   logic [5:0] screen_rows_ff;
   logic       q_valid, q_pop;
   qent_type   q_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff  <= RESET_COLOR;
         screen_rows_ff <= RESET_ROWS;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TEXT_COLOR:  text_color_ff  <= csr_write_data;
            CSR_SCREEN_ROWS: screen_rows_ff <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   ttws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   ttws_back #(
      .LINE_WIDTH    (LINE_WIDTH),
      .HISTORY_LINES (HISTORY_LINES),
      .MAX_ROWS      (MAX_ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .text_color  (text_color_ff),
      .screen_rows (screen_rows_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

/* src/ttws_checker.sv */
// ttws_checker: port-level checks of the text terminal, bound to the top level.
// Depends on ttws_pkg and text_terminal_with_scrollback.
module ttws_checker
   import ttws_pkg::*;
#(
   parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Cursor address follows row and column
   a_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cursor_address ==
         12'(16'(rsp_data.cursor_row) * 16'(LINE_WIDTH) + 16'(rsp_data.cursor_column)))
      else $error("cursor address mismatch");

   // Column stays on the line
   a_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 8'(rsp_data.cursor_column) < 8'(LINE_WIDTH))
      else $error("cursor column beyond line");

   // Scrolled flag tracks a nonzero offset
   a_view: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.view_scrolled == (rsp_data.view_offset != 10'd0))
      else $error("scrolled flag disagrees with offset");

endmodule

bind text_terminal_with_scrollback ttws_checker #(.LINE_WIDTH(LINE_WIDTH)) u_ttws_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/text_terminal_with_scrollback_checker.sv */
// Checker for the text terminal: watches request, response and register ports,
// predicts each response and compares it field by field. Depends on ttws_pkg.
module text_terminal_with_scrollback_checker
   import ttws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data,
   output int         error_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH   = LINE_WIDTH_DEF;
   localparam int HIST    = HISTORY_LINES_DEF;
   localparam int ROWSMAX = MAX_ROWS_DEF;

   // Predicted terminal state
   logic [7:0]  color;
   logic [5:0]  rows_reg;
   logic [15:0] screen [ROWSMAX*WIDTH];
   logic [15:0] history [HIST*WIDTH];
   int          head, fill, row, col, offset;
   bit          scrolled;
   rsp_type     expected_q[$];

   assign pending_count = expected_q.size();

   function automatic int rows_in_use();
      int r;
      r = rows_reg;
      if (r < 2) r = 2;
      if (r > ROWSMAX) r = ROWSMAX;
      return r;
   endfunction

   function automatic logic [15:0] blank();
      return {color, CHAR_SPACE};
   endfunction

   // Push the top line into history, shift rows up, clear the bottom
   function automatic void scroll_up();
      int n;
      n = rows_in_use();
      for (int x = 0; x < WIDTH; x++) history[head*WIDTH+x] = screen[x];
      head = (head + 1) % HIST;
      if (fill < HIST) fill++;
      for (int y = 0; y + 1 < n; y++)
         for (int x = 0; x < WIDTH; x++) screen[y*WIDTH+x] = screen[(y+1)*WIDTH+x];
      for (int x = 0; x < WIDTH; x++) screen[(n-1)*WIDTH+x] = blank();
      offset = 0;
      scrolled = 0;
   endfunction

   function automatic void type_char(logic [7:0] c);
      int n;
      n = rows_in_use();
      offset = 0;
      scrolled = 0;
      if (row >= n) begin
         scroll_up();
         row = n - 1;
      end
      if (c == CHAR_NEWLINE) begin
         row++;
         col = 0;
      end else if (c == CHAR_BACKSPACE) begin
         if (col > 0) begin
            col--;
            screen[row*WIDTH+col] = blank();
         end
      end else begin
         screen[row*WIDTH+col] = {color, c};
         col++;
         if (col >= WIDTH) begin
            col = 0;
            row++;
            if (row >= n) begin
               scroll_up();
               row = n - 1;
            end
         end
      end
   endfunction

   function automatic logic [15:0] displayed_cell(int y, int x);
      int n, age, slot;
      n = rows_in_use();
      if (y >= n || x >= WIDTH) return 16'h0;
      if (!scrolled || offset == 0) return screen[y*WIDTH+x];
      if (y == 0 && x + MARK_LEN >= WIDTH)
         return {MARK_ATTR, mark_char(4'(x + MARK_LEN - WIDTH))};
      age = offset - 1 + (n - 1 - y);
      if (age >= fill) return blank();
      slot = (head + HIST - 1 - age) % HIST;
      return history[slot*WIDTH+x];
   endfunction

   function automatic rsp_type terminal_step(req_type r);
      rsp_type o;
      int n;
      logic [15:0] cell_val;
      n = rows_in_use();
      cell_val = '0;
      case (op_type'(r.mode))
         OP_PUT:  type_char(r.char_code);
         OP_UP:   if (offset < fill && offset + n < HIST) begin
               offset++;
               scrolled = 1;
            end
         OP_DOWN: if (offset > 0) begin
               offset--;
               scrolled = (offset != 0);
            end
         default: cell_val = displayed_cell(r.read_row, r.read_column);
      endcase
      o.cursor_row     = 6'(row);
      o.cursor_column  = 7'(col);
      o.cursor_address = 12'(row * WIDTH + col);
      o.view_scrolled  = scrolled;
      o.view_offset    = 10'(offset);
      o.cell_value     = cell_val;
      return o;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         color = RESET_COLOR;
         rows_reg = RESET_ROWS;
         for (int i = 0; i < ROWSMAX*WIDTH; i++) screen[i] = RESET_BLANK;
         head = 0; fill = 0; row = 0; col = 0; offset = 0; scrolled = 0;
         expected_q.delete();
         error_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_TEXT_COLOR) color = csr_write_data;
            else rows_reg = csr_write_data[5:0];
         end
         if (req_valid && req_ready) expected_q.push_back(terminal_step(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected response", 1, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.cursor_row != want.cursor_row)
                  report("cursor_row", rsp_data.cursor_row, want.cursor_row);
               if (rsp_data.cursor_column != want.cursor_column)
                  report("cursor_column", rsp_data.cursor_column, want.cursor_column);
               if (rsp_data.cursor_address != want.cursor_address)
                  report("cursor_address", rsp_data.cursor_address, want.cursor_address);
               if (rsp_data.view_scrolled != want.view_scrolled)
                  report("view_scrolled", rsp_data.view_scrolled, want.view_scrolled);
               if (rsp_data.view_offset != want.view_offset)
                  report("view_offset", rsp_data.view_offset, want.view_offset);
               if (rsp_data.cell_value != want.cell_value)
                  report("cell_value", rsp_data.cell_value, want.cell_value);
            end
         end
      end
   end

endmodule

/* tb/text_terminal_with_scrollback_tb.sv */
// Testbench top for the text terminal: clock, reset, request and register stimulus,
// verdict. Depends on ttws_pkg, the block and text_terminal_with_scrollback_checker.
module text_terminal_with_scrollback_tb;
   import ttws_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 60000;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 0;
   logic       csr_index = CSR_TEXT_COLOR;
   logic [7:0] csr_write_data = '0;
   int         error_count, pending_count;
   int         idle_cycles = 0;
   bit         stim_done = 0;

   text_terminal_with_scrollback dut (.*);
   text_terminal_with_scrollback_checker checker_i (.*);

   always #6 clock = ~clock;

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   // Watchdog on cycles with no accepted request or response
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response side: random stalls, with a quiet stretch
   initial begin
      int g;
      forever begin
         @(negedge clock);
         g = gap_len();
         if (stim_done || $realtime < 200000) rsp_ready <= 1;
         else if (g == 0) rsp_ready <= 1;
         else begin
            rsp_ready <= 0;
            repeat (g) @(negedge clock);
            rsp_ready <= 1;
         end
      end
   end

   // Valid stays high into the next request when there is no gap
   task automatic send(op_type op, logic [7:0] c, logic [5:0] r, logic [6:0] x);
      req_type t;
      int g;
      t.mode = op; t.char_code = c; t.read_row = r; t.read_column = x;
      req_valid <= 1;
      req_data <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      g = gap_len();
      if (g != 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (4200) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] v);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 0;
      @(negedge clock);
   endtask

   // Random request mix: mostly typing and view movement, some reads
   task automatic random_phase(int n);
      int p;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         if (p < 40) send(OP_PUT, 8'($urandom_range(32, 126)), '0, '0);
         else if (p < 48) send(OP_PUT, CHAR_NEWLINE, 6'($urandom), 7'($urandom));
         else if (p < 52) send(OP_PUT, CHAR_BACKSPACE, '0, '0);
         else if (p < 55) send(OP_PUT, 8'($urandom), 6'($urandom), 7'($urandom));
         else if (p < 66) send(OP_UP, 8'($urandom), '0, '0);
         else if (p < 72) send(OP_DOWN, 8'($urandom), '0, '0);
         else if (p < 96)
            send(OP_READ, 8'($urandom), 6'($urandom_range(0, 51)),
                 7'($urandom_range(0, 81)));
         else send(OP_READ, '0, 6'($urandom), 7'($urandom));
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 0;
      // Directed: extremes, each operation, special cases
      send(OP_PUT, CHAR_BACKSPACE, '0, '0);
      send(OP_DOWN, '0, '0, '0);
      send(OP_UP, '0, '0, '0);
      send(OP_PUT, 8'hFF, '0, '0);
      send(OP_PUT, 8'h00, '0, '0);
      send(OP_PUT, CHAR_BACKSPACE, '0, '0);
      send(OP_READ, '0, 6'd0, 7'd0);
      send(OP_READ, '0, 6'd63, 7'd127);
      send(OP_READ, '0, 6'd24, 7'd80);
      send(OP_READ, '0, 6'd25, 7'd79);
      drain();
      write_reg(CSR_SCREEN_ROWS, 8'd2);
      write_reg(CSR_TEXT_COLOR, 8'hFF);
      for (int i = 0; i < 3; i++) send(OP_PUT, CHAR_NEWLINE, '0, '0);
      for (int i = 0; i < 82; i++) send(OP_PUT, 8'($urandom_range(33, 126)), '0, '0);
      send(OP_UP, '0, '0, '0);
      send(OP_READ, '0, 6'd0, 7'd70);
      send(OP_READ, '0, 6'd0, 7'd79);
      send(OP_READ, '0, 6'd1, 7'd5);
      send(OP_UP, '0, '0, '0);
      send(OP_UP, '0, '0, '0);
      send(OP_READ, '0, 6'd0, 7'd69);
      send(OP_PUT, 8'h41, '0, '0);
      drain();
      // Random phases over several register settings
      write_reg(CSR_TEXT_COLOR, 8'h00);
      write_reg(CSR_SCREEN_ROWS, 8'd0);
      random_phase(130);
      drain();
      write_reg(CSR_TEXT_COLOR, 8'($urandom));
      write_reg(CSR_SCREEN_ROWS, 8'd63);
      random_phase(100);
      drain();
      write_reg(CSR_TEXT_COLOR, 8'($urandom));
      write_reg(CSR_SCREEN_ROWS, 8'($urandom_range(2, 12)));
      random_phase(120);
      drain();
      write_reg(CSR_TEXT_COLOR, 8'h07);
      write_reg(CSR_SCREEN_ROWS, 8'd25);
      random_phase(90);
      stim_done = 1;
      drain();
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
